FILE: src/arc_pkg.sv
// arc_pkg: types and constants shared by the ARP reply cache.
// Holds the item and result payloads, the table write request and the ARP check values.
// No dependencies.
`default_nettype none

package arc_pkg;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;

	localparam logic       CMD_HEADER = 1'b0;
	localparam logic       CMD_LOOKUP = 1'b1;

	localparam logic [10:0] MIN_ARP_FRAME = 11'd42;
	localparam logic [15:0] HW_ETHERNET   = 16'h0001;
	localparam logic [15:0] PROTO_IPV4    = 16'h0800;
	localparam logic [15:0] OP_REPLY      = 16'h0002;

	typedef struct packed {
		logic             command;
		logic [10:0]      frame_length;
		logic [15:0]      hw_type;
		logic [15:0]      proto_type;
		logic [15:0]      operation;
		logic [MAC_W-1:0] sender_mac;
		logic [IP_W-1:0]  sender_ip;
		logic [IP_W-1:0]  query_ip;
	} arc_item_t;

	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
		logic             send_request;
		logic [IP_W-1:0]  request_sender_ip;
		logic [IP_W-1:0]  request_query_ip;
		logic             stored;
	} arc_result_t;

	typedef struct packed {
		logic             en;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} arc_store_t;

endpackage

`default_nettype wire

FILE: src/arc_item_if.sv
// arc_item_if: valid/ready channel carrying one input item of the ARP reply cache.
// Depends on arc_pkg.
`default_nettype none

interface arc_item_if;
	import arc_pkg::*;

	logic      valid;
	logic      ready;
	arc_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/arc_result_if.sv
// arc_result_if: valid/ready channel carrying one result of the ARP reply cache.
// Depends on arc_pkg.
`default_nettype none

interface arc_result_if;
	import arc_pkg::*;

	logic        valid;
	logic        ready;
	arc_result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/arc_cfg_if.sv
// arc_cfg_if: valid/ready write channel for the local IPv4 address register.
// Depends on arc_pkg.
`default_nettype none

interface arc_cfg_if;
	import arc_pkg::*;

	logic            valid;
	logic            ready;
	logic [IP_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/arc_table.sv
// arc_table: IPv4 to MAC table with parallel compare, priority pick and one write per cycle.
// Depends on arc_pkg.
`default_nettype none

module arc_table #(
	parameter int Entries = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire  arc_pkg::arc_store_t  store,
	input  wire  [arc_pkg::IP_W-1:0]   lookup_ip,
	output logic                       hit,
	output logic [arc_pkg::MAC_W-1:0]  hit_mac
);
	import arc_pkg::*;

	localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;

	logic [Entries-1:0] valid_q;
	logic [IP_W-1:0]    ip_q  [Entries];
	logic [MAC_W-1:0]   mac_q [Entries];

	logic [IdxW-1:0] slot;
	logic [IdxW-1:0] hit_idx;

	always_comb begin
		slot    = '0;
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = Entries - 1; i >= 0; i--) begin
			if (!valid_q[i] || ip_q[i] == store.ip) begin
				slot = IdxW'(i);
			end
			if (valid_q[i] && ip_q[i] == lookup_ip) begin
				hit     = 1'b1;
				hit_idx = IdxW'(i);
			end
		end
	end

	assign hit_mac = mac_q[hit_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (store.en) begin
			valid_q[slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (store.en) begin
			ip_q[slot]  <= store.ip;
			mac_q[slot] <= store.mac;
		end
	end

endmodule

`default_nettype wire

FILE: src/arp_reply_cache_core.sv
// arp_reply_cache_core: ARP reply cache, stores valid ARP replies and answers IPv4 lookups.
// Depends on arc_pkg, arc_item_if, arc_result_if, arc_cfg_if and arc_table.
//
//   port     direction  payload        transaction
//   item     sink       arc_item_t     header (command 0) or lookup (command 1)
//   result   source     arc_result_t   one per item, in item order
//   cfg      sink       local_ip       register write, always ready
//
// An item is registered on acceptance and its result when it advances; one item per cycle
// while results are taken. The table compare, slot pick and write sit between the input
// and result registers, so a lookup sees every header accepted before it. Reset clears all
// valid marks at once. A stalled result holds the result register; the input register
// still takes an item while the result register is free or being taken.
`default_nettype none

module arp_reply_cache_core #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	arc_item_if.sink     item,
	arc_result_if.source result,
	arc_cfg_if.sink      cfg
);
	import arc_pkg::*;

	logic [IP_W-1:0] local_ip_val_q;

	logic        item_v_s1;
	arc_item_t   item_s1;
	logic        res_v_q;
	arc_result_t res_q;

	logic        advance;
	logic        header_ok;
	logic        is_lookup;
	logic        tbl_hit;
	logic [MAC_W-1:0] tbl_mac;
	arc_store_t  store;
	arc_result_t res_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_val_q <= '0;
		end else if (cfg.valid) begin
			local_ip_val_q <= cfg.data;
		end
	end

	assign advance    = item_v_s1 && (!res_v_q || result.ready);
	assign item.ready = !item_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (item.ready) begin
			item_v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	assign is_lookup = item_s1.command == CMD_LOOKUP;
	assign header_ok = item_s1.command == CMD_HEADER &&
		item_s1.frame_length >= MIN_ARP_FRAME &&
		item_s1.hw_type == HW_ETHERNET &&
		item_s1.proto_type == PROTO_IPV4 &&
		item_s1.operation == OP_REPLY;

	assign store.en  = advance && header_ok;
	assign store.ip  = item_s1.sender_ip;
	assign store.mac = item_s1.sender_mac;

	arc_table #(
		.Entries (CACHE_ENTRIES)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.store     (store),
		.lookup_ip (item_s1.query_ip),
		.hit       (tbl_hit),
		.hit_mac   (tbl_mac)
	);

	always_comb begin
		res_d                   = '0;
		res_d.hit               = is_lookup && tbl_hit;
		res_d.mac               = (is_lookup && tbl_hit) ? tbl_mac : '0;
		res_d.send_request      = is_lookup && !tbl_hit;
		res_d.request_sender_ip = (is_lookup && !tbl_hit) ? local_ip_val_q : '0;
		res_d.request_query_ip  = (is_lookup && !tbl_hit) ? item_s1.query_ip : '0;
		res_d.stored            = header_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (advance) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_v_q;
	assign result.data  = res_q;

	a_hit_xor_request: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q |-> !(res_q.hit && res_q.send_request))
		else $error("hit and request raised together");

	a_stored_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && res_q.stored) |-> (!res_q.hit && !res_q.send_request))
		else $error("stored result carries lookup fields");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_v_q)
		else $error("result register not filled after advance");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(item_v_s1 && !advance) |=> (item_v_s1 && $stable(item_s1)))
		else $error("stalled input register changed");

	a_store_header: assert property (@(posedge clk) disable iff (!arst_n)
		store.en |-> (item_v_s1 && !is_lookup))
		else $error("table written without a header in flight");

endmodule

`default_nettype wire

FILE: dv/tb_arp_reply_cache_core.sv
// tb_arp_reply_cache_core: self-checking testbench for the ARP reply cache core.
// Drives ARP headers, lookups and local IP writes, predicts every result from a shadow table.
// Depends on arc_pkg, arc_item_if, arc_result_if, arc_cfg_if and arp_reply_cache_core.
`default_nettype none

module tb_arp_reply_cache_core;
	import arc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TABLE_DEPTH   = 16;
	localparam int          POOL_SIZE     = 24;
	localparam int          PHASE_ITEMS   = 265;
	localparam logic [15:0] PROTO_ARP     = 16'h0806;
	localparam logic [15:0] OP_REQUEST    = 16'h0001;

	logic clk = 1'b0;
	logic arst_n;

	arc_item_if   item();
	arc_result_if result();
	arc_cfg_if    cfg();

	arp_reply_cache_core #(.CACHE_ENTRIES(TABLE_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	logic [IP_W-1:0]  shadow_ip    [TABLE_DEPTH];
	logic [MAC_W-1:0] shadow_mac   [TABLE_DEPTH];
	bit               shadow_valid [TABLE_DEPTH];
	logic [IP_W-1:0]  shadow_local_ip = '0;

	arc_item_t   queued_arp_items[$];
	arc_result_t predicted_answers[$];
	logic [IP_W-1:0] ip_pool [POOL_SIZE];

	bit item_taken   = 1'b0;
	bit result_taken = 1'b0;
	bit cfg_taken    = 1'b0;
	bit no_idle      = 1'b0;
	bit mismatch_seen = 1'b0;
	int item_gap     = 0;
	int ready_stall  = 0;
	int items_queued   = 0;
	int items_accepted = 0;
	int answers_seen   = 0;
	arc_result_t oldest_answer;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [MAC_W-1:0] m;
		m[47:32] = 16'($urandom);
		m[31:0]  = $urandom;
		return m;
	endfunction

	function automatic logic [IP_W-1:0] pick_ip();
		if ($urandom_range(0, 99) < 85)
			return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic arc_item_t header_item(input logic [10:0] flen, input logic [15:0] hw,
			input logic [15:0] proto, input logic [15:0] op, input logic [MAC_W-1:0] mac,
			input logic [IP_W-1:0] ip);
		arc_item_t it;
		it.command      = CMD_HEADER;
		it.frame_length = flen;
		it.hw_type      = hw;
		it.proto_type   = proto;
		it.operation    = op;
		it.sender_mac   = mac;
		it.sender_ip    = ip;
		it.query_ip     = $urandom;
		return it;
	endfunction

	function automatic arc_item_t lookup_item(input logic [IP_W-1:0] ip);
		arc_item_t it;
		it = header_item(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			rand_mac(), $urandom);
		it.command  = CMD_LOOKUP;
		it.query_ip = ip;
		return it;
	endfunction

	function automatic arc_item_t random_item();
		arc_item_t   it;
		int          kind;
		logic [15:0] flip;
		kind = $urandom_range(0, 99);
		flip = 16'($urandom_range(1, 65535));
		it = header_item(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			rand_mac(), pick_ip());
		it.query_ip = pick_ip();
		if (kind < 45) begin
			it.command = CMD_LOOKUP;
		end else if (kind < 95) begin
			it.frame_length = 11'($urandom_range(42, 2047));
			it.hw_type      = HW_ETHERNET;
			it.proto_type   = PROTO_IPV4;
			it.operation    = OP_REPLY;
			if (kind >= 85) begin
				case ($urandom_range(0, 3))
					0: it.frame_length = 11'($urandom_range(0, 41));
					1: it.hw_type = HW_ETHERNET ^ flip;
					2: it.proto_type = $urandom_range(0, 1) ? PROTO_ARP : PROTO_IPV4 ^ flip;
					default: it.operation = $urandom_range(0, 1) ? OP_REQUEST : OP_REPLY ^ flip;
				endcase
			end
		end
		return it;
	endfunction

	function automatic arc_result_t resolve_arp_item(input arc_item_t it);
		arc_result_t r;
		int          slot;
		bit          found;
		r = '0;
		slot = 0;
		found = 1'b0;
		if (it.command == CMD_HEADER) begin
			if (it.frame_length >= MIN_ARP_FRAME && it.hw_type == HW_ETHERNET &&
					it.proto_type == PROTO_IPV4 && it.operation == OP_REPLY) begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!found && (!shadow_valid[i] || shadow_ip[i] == it.sender_ip)) begin
						slot = i;
						found = 1'b1;
					end
				end
				shadow_ip[slot]    = it.sender_ip;
				shadow_mac[slot]   = it.sender_mac;
				shadow_valid[slot] = 1'b1;
				r.stored = 1'b1;
			end
		end else begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (!found && shadow_valid[i] && shadow_ip[i] == it.query_ip) begin
					r.hit = 1'b1;
					r.mac = shadow_mac[i];
					found = 1'b1;
				end
			end
			if (!found) begin
				r.send_request      = 1'b1;
				r.request_sender_ip = shadow_local_ip;
				r.request_query_ip  = it.query_ip;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
		mismatch_seen = 1'b1;
	endtask

	task automatic check_answer(input arc_result_t want, input arc_result_t got);
		if (got.hit !== want.hit)
			report_mismatch("hit", 64'(want.hit), 64'(got.hit));
		if (got.mac !== want.mac)
			report_mismatch("mac", 64'(want.mac), 64'(got.mac));
		if (got.send_request !== want.send_request)
			report_mismatch("send_request", 64'(want.send_request), 64'(got.send_request));
		if (got.request_sender_ip !== want.request_sender_ip)
			report_mismatch("request_sender_ip", 64'(want.request_sender_ip),
				64'(got.request_sender_ip));
		if (got.request_query_ip !== want.request_query_ip)
			report_mismatch("request_query_ip", 64'(want.request_query_ip),
				64'(got.request_query_ip));
		if (got.stored !== want.stored)
			report_mismatch("stored", 64'(want.stored), 64'(got.stored));
	endtask

	always @(posedge clk) begin
		item_taken   = item.valid && item.ready;
		result_taken = result.valid && result.ready;
		cfg_taken    = cfg.valid && cfg.ready;
		if (cfg_taken)
			shadow_local_ip = cfg.data;
		if (result_taken) begin
			answers_seen++;
			if (predicted_answers.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual %h",
					$time, result.data);
				mismatch_seen = 1'b1;
			end else begin
				oldest_answer = predicted_answers.pop_front();
				check_answer(oldest_answer, result.data);
			end
		end
		if (item_taken) begin
			items_accepted++;
			predicted_answers.push_back(resolve_arp_item(item.data));
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!item.valid || item_taken)) begin
			if (item_gap > 0) begin
				item.valid <= 1'b0;
				item_gap--;
			end else if (queued_arp_items.size() != 0) begin
				item.data  <= queued_arp_items.pop_front();
				item.valid <= 1'b1;
				item_gap = draw_gap();
				if ($urandom_range(0, 39) == 0)
					no_idle <= !no_idle;
			end else begin
				item.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken)
				ready_stall = draw_gap();
			if (ready_stall > 0) begin
				result.ready <= 1'b0;
				ready_stall--;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic queue_item(input arc_item_t it);
		queued_arp_items.push_back(it);
		items_queued++;
	endtask

	task automatic wait_idle();
		while (items_accepted != items_queued || answers_seen != items_accepted)
			@(negedge clk);
	endtask

	task automatic write_local_ip(input logic [IP_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(negedge clk); while (!cfg_taken);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [IP_W-1:0] phase_ip [5];
		item.valid   = 1'b0;
		item.data    = '0;
		result.ready = 1'b0;
		cfg.valid    = 1'b0;
		cfg.data     = '0;
		arst_n       = 1'b0;
		ip_pool[0] = 32'h0000_0000;
		ip_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 10; i++)
			ip_pool[i] = 32'h0A00_0100 + 32'(i) - 32'd2;
		for (int i = 10; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(posedge clk);
		queue_item(lookup_item(32'h0A00_0001));
		wait_idle();
		write_local_ip(32'hC0A8_0001);

		@(posedge clk);
		queue_item(header_item(11'd41, HW_ETHERNET, PROTO_IPV4, OP_REPLY, rand_mac(),
			32'h0A00_0001));
		queue_item(header_item(11'd42, HW_ETHERNET, PROTO_IPV4, OP_REPLY, '0, '0));
		queue_item(header_item(11'd2047, HW_ETHERNET, PROTO_IPV4, OP_REPLY, '1, '1));
		queue_item(header_item(11'd60, 16'h0000, PROTO_IPV4, OP_REPLY, rand_mac(), '0));
		queue_item(header_item(11'd60, HW_ETHERNET, PROTO_ARP, OP_REPLY, rand_mac(), '0));
		queue_item(header_item(11'd60, HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand_mac(), '0));
		queue_item(lookup_item('0));
		queue_item(header_item(11'd64, HW_ETHERNET, PROTO_IPV4, OP_REPLY, 48'h0123_4567_89AB,
			'0));
		queue_item(lookup_item('0));
		queue_item(lookup_item('1));
		for (int i = 0; i < TABLE_DEPTH - 2; i++)
			queue_item(header_item(11'd42, HW_ETHERNET, PROTO_IPV4, OP_REPLY, rand_mac(),
				32'h0A00_0100 + 32'(i)));
		queue_item(header_item(11'd42, HW_ETHERNET, PROTO_IPV4, OP_REPLY, rand_mac(),
			32'h0A00_01FF));
		queue_item(lookup_item('0));
		queue_item(lookup_item(32'h0A00_01FF));
		wait_idle();

		phase_ip[0] = 32'hFFFF_FFFF;
		phase_ip[1] = $urandom;
		phase_ip[2] = 32'h0000_0000;
		phase_ip[3] = $urandom;
		phase_ip[4] = 32'h5A5A_A5A5;
		for (int p = 0; p < 5; p++) begin
			write_local_ip(phase_ip[p]);
			@(posedge clk);
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_item(random_item());
			wait_idle();
		end

		repeat (4) @(negedge clk);
		if (predicted_answers.size() != 0) begin
			$display("%0t: result transactions missing, expected %0d more, actual 0",
				$time, predicted_answers.size());
			mismatch_seen = 1'b1;
		end
		if (!mismatch_seen)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
src/arc_pkg.sv
src/arc_item_if.sv
src/arc_result_if.sv
src/arc_cfg_if.sv
src/arc_table.sv
src/arp_reply_cache_core.sv
dv/tb_arp_reply_cache_core.sv
